// ===== hw/rtl/ftpd_pkg.sv =====
`timescale 1ns / 1ps

package ftpd_pkg;

	// fixed field widths
	localparam int FLIPPER_COUNT = 4;
	localparam int GAIN_W        = 24;
	localparam int STEP_W        = 21;
	localparam int AXIS_W        = 16;
	localparam int TORQUE_W      = 32;
	localparam int CFG_W         = 24;
	localparam int CFG_IDX_W     = 2;

	// jog product and rounded jog step
	localparam int JP_W = STEP_W + 1 + AXIS_W;
	localparam int DQ_W = 24;
	localparam int JOG_FRAC = 14;

	// torque product is LSB 2^-28, result LSB 2^-16
	localparam int TQ_SHIFT = 12;

	// flipper slots
	localparam int IX_FR = 0;
	localparam int IX_FL = 1;
	localparam int IX_RR = 2;
	localparam int IX_RL = 3;

	// front pair moves opposite to the stick
	localparam logic [FLIPPER_COUNT-1:0] FRONT_MASK = 4'b0011;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_GAIN = 2'd0,
		REG_RATE_GAIN  = 2'd1,
		REG_STEP_LIMIT = 2'd2,
		REG_JOG_SCALE  = 2'd3
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 24'd204800;
	localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 24'd5120000;
	localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 21'd524;
	localparam logic [STEP_W-1:0] JOG_SCALE_RST  = 21'd524;

	typedef logic [FLIPPER_COUNT-1:0] flip_mask_t;

endpackage

// ===== hw/rtl/flipper_target_pd_servo.sv =====
`timescale 1ns / 1ps

// flipper target and pd torque servo, four flippers
// input channel (in_valid/in_ready): one beat per control tick with the
//   joystick fields and the four measured flipper angles
// output channel (out_valid/out_ready): one beat per input beat with the
//   four saturated torques, in input order
// config port: cfg_we/cfg_index/cfg_data writes gains, step limit and jog scale;
//   write only while no beat is in flight
// throughput: one beat per cycle while the receiver takes every beat, through
//   a 4-stage pipeline (input/jog step, target update, gain multiplies,
//   round/saturate) with the target state updated in stage 2
// reset: config registers take their defaults, the pipeline empties and the
//   servo is unprimed; the first beat loads targets and previous angles from
//   its measured angles
// receiver stall: each stage holds while the stage after it is full and held, so
//   bubbles close up and in_ready drops only once all four stages are full
module flipper_target_pd_servo #(
	parameter int ANGLE_WIDTH = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    cfg_we,
	input  logic [ftpd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ftpd_pkg::CFG_W-1:0]              cfg_data,

	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    update_targets,
	input  logic                                    equalize_button,
	input  logic                                    front_left_select,
	input  logic                                    front_right_select,
	input  logic signed [ftpd_pkg::AXIS_W-1:0]      stick_vertical,
	input  logic signed [ftpd_pkg::AXIS_W-1:0]      trigger_left,
	input  logic signed [ftpd_pkg::AXIS_W-1:0]      trigger_right,
	input  logic signed [ANGLE_WIDTH-1:0]           angle_front_right,
	input  logic signed [ANGLE_WIDTH-1:0]           angle_front_left,
	input  logic signed [ANGLE_WIDTH-1:0]           angle_rear_right,
	input  logic signed [ANGLE_WIDTH-1:0]           angle_rear_left,

	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [ftpd_pkg::TORQUE_W-1:0]    torque_front_right,
	output logic signed [ftpd_pkg::TORQUE_W-1:0]    torque_front_left,
	output logic signed [ftpd_pkg::TORQUE_W-1:0]    torque_rear_right,
	output logic signed [ftpd_pkg::TORQUE_W-1:0]    torque_rear_left
);

	localparam int AW   = ANGLE_WIDTH;
	localparam int NF   = ftpd_pkg::FLIPPER_COUNT;
	// working width for target arithmetic
	localparam int SW   = ((AW > ftpd_pkg::DQ_W) ? AW : ftpd_pkg::DQ_W) + 2;
	localparam int SUMW = AW + 2;
	localparam int EW   = AW + 1;
	localparam int PW   = EW + ftpd_pkg::GAIN_W + 1;
	localparam int ACCW = PW + 1;
	localparam int JPW  = ftpd_pkg::JP_W;

	localparam logic signed [SW-1:0]   ANG_HI = SW'({(AW-1){1'b1}});
	localparam logic signed [SW-1:0]   ANG_LO = ~ANG_HI;
	localparam logic signed [ACCW-1:0] TQ_HI  = ACCW'({(ftpd_pkg::TORQUE_W-1){1'b1}});
	localparam logic signed [ACCW-1:0] TQ_LO  = ~TQ_HI;

	function automatic logic signed [AW-1:0] sat_angle(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] y;
		begin
			y = x;
			if (x > ANG_HI) begin
				y = ANG_HI;
			end else if (x < ANG_LO) begin
				y = ANG_LO;
			end
			return AW'(y);
		end
	endfunction

	// configuration registers
	logic [ftpd_pkg::GAIN_W-1:0] angle_gain_q;
	logic [ftpd_pkg::GAIN_W-1:0] rate_gain_q;
	logic [ftpd_pkg::STEP_W-1:0] step_limit_q;
	logic [ftpd_pkg::STEP_W-1:0] jog_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_gain_q <= ftpd_pkg::ANGLE_GAIN_RST;
			rate_gain_q  <= ftpd_pkg::RATE_GAIN_RST;
			step_limit_q <= ftpd_pkg::STEP_LIMIT_RST;
			jog_scale_q  <= ftpd_pkg::JOG_SCALE_RST;
		end else if (cfg_we) begin
			case (ftpd_pkg::cfg_reg_t'(cfg_index))
				ftpd_pkg::REG_ANGLE_GAIN: angle_gain_q <= cfg_data;
				ftpd_pkg::REG_RATE_GAIN:  rate_gain_q  <= cfg_data;
				ftpd_pkg::REG_STEP_LIMIT: step_limit_q <= ftpd_pkg::STEP_W'(cfg_data);
				ftpd_pkg::REG_JOG_SCALE:  jog_scale_q  <= ftpd_pkg::STEP_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// stage valids and elastic enables: a stage loads when empty or draining
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: capture the beat, form the rounded jog step and the jog mask
	logic signed [JPW-1:0]              jog_prod;
	logic signed [JPW-1:0]              jog_rnd;
	ftpd_pkg::flip_mask_t               sel_raw;
	ftpd_pkg::flip_mask_t               sel_in;

	always_comb begin
		jog_prod = JPW'($signed({1'b0, jog_scale_q})) * JPW'(stick_vertical);
		jog_rnd  = jog_prod + JPW'(2 ** (ftpd_pkg::JOG_FRAC - 1));
		sel_raw  = '0;
		sel_raw[ftpd_pkg::IX_FR] = front_right_select;
		sel_raw[ftpd_pkg::IX_FL] = front_left_select;
		sel_raw[ftpd_pkg::IX_RR] = trigger_right > 0;
		sel_raw[ftpd_pkg::IX_RL] = trigger_left > 0;
		// nothing chosen: all four move
		sel_in = (sel_raw == '0) ? '1 : sel_raw;
	end

	logic                               upd_s1;
	logic                               eq_s1;
	ftpd_pkg::flip_mask_t               sel_s1;
	logic signed [ftpd_pkg::DQ_W-1:0]   dq_s1;
	logic signed [AW-1:0]               ang_s1 [NF];

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			upd_s1 <= update_targets;
			eq_s1  <= equalize_button;
			sel_s1 <= sel_in;
			dq_s1  <= ftpd_pkg::DQ_W'(jog_rnd >>> ftpd_pkg::JOG_FRAC);
			ang_s1[ftpd_pkg::IX_FR] <= angle_front_right;
			ang_s1[ftpd_pkg::IX_FL] <= angle_front_left;
			ang_s1[ftpd_pkg::IX_RR] <= angle_rear_right;
			ang_s1[ftpd_pkg::IX_RL] <= angle_rear_left;
		end
	end

	// stage 2: target update against the servo state
	logic                               primed_q;
	logic signed [AW-1:0]               tgt_q  [NF];
	logic signed [AW-1:0]               prev_q [NF];

	logic signed [AW-1:0]               base_t [NF];
	logic signed [AW-1:0]               base_p [NF];
	logic signed [AW-1:0]               new_t  [NF];
	logic signed [SUMW-1:0]             sum_t;
	logic signed [SUMW-1:0]             sum_r;
	logic signed [SW-1:0]               mean_w;
	logic signed [SW-1:0]               lim_w;
	logic signed [SW-1:0]               diff_w;
	logic signed [SW-1:0]               dq_w;
	logic signed [AW-1:0]               eq_t;
	logic signed [AW-1:0]               jog_t;

	always_comb begin
		sum_t = '0;
		for (int i = 0; i < NF; i++) begin
			// unprimed: the first beat seeds targets and previous angles
			base_t[i] = primed_q ? tgt_q[i]  : ang_s1[i];
			base_p[i] = primed_q ? prev_q[i] : ang_s1[i];
			sum_t     = sum_t + SUMW'(base_t[i]);
		end
		// mean rounded half up
		sum_r  = sum_t + SUMW'(2);
		mean_w = SW'(sum_r >>> 2);
		lim_w  = SW'($signed({1'b0, step_limit_q}));
		dq_w   = SW'(dq_s1);
		for (int i = 0; i < NF; i++) begin
			diff_w = mean_w - SW'(base_t[i]);
			if (diff_w > lim_w) begin
				diff_w = lim_w;
			end else if (diff_w < -lim_w) begin
				diff_w = -lim_w;
			end
			eq_t = sat_angle(SW'(base_t[i]) + diff_w);
			if (!sel_s1[i]) begin
				jog_t = base_t[i];
			end else if (ftpd_pkg::FRONT_MASK[i]) begin
				jog_t = sat_angle(SW'(base_t[i]) - dq_w);
			end else begin
				jog_t = sat_angle(SW'(base_t[i]) + dq_w);
			end
			if (!upd_s1) begin
				new_t[i] = base_t[i];
			end else if (eq_s1) begin
				new_t[i] = eq_t;
			end else begin
				new_t[i] = jog_t;
			end
		end
	end

	logic stage2_load;
	assign stage2_load = v_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (stage2_load) begin
			primed_q <= 1'b1;
		end
	end

	logic signed [EW-1:0] err_s2   [NF];
	logic signed [EW-1:0] delta_s2 [NF];

	always_ff @(posedge clk) begin
		if (stage2_load) begin
			for (int i = 0; i < NF; i++) begin
				tgt_q[i]    <= new_t[i];
				prev_q[i]   <= ang_s1[i];
				err_s2[i]   <= EW'(new_t[i]) - EW'(ang_s1[i]);
				delta_s2[i] <= EW'(ang_s1[i]) - EW'(base_p[i]);
			end
		end
	end

	// stage 3: gain products, LSB 2^-28
	logic signed [PW-1:0] pa_s3 [NF];
	logic signed [PW-1:0] pr_s3 [NF];

	always_ff @(posedge clk) begin
		if (v_s2 && en3) begin
			for (int i = 0; i < NF; i++) begin
				pa_s3[i] <= PW'($signed({1'b0, angle_gain_q})) * PW'(err_s2[i]);
				pr_s3[i] <= PW'($signed({1'b0, rate_gain_q})) * PW'(delta_s2[i]);
			end
		end
	end

	// stage 4: difference, round half up to 2^-16, saturate
	logic signed [ACCW-1:0]               acc_w [NF];
	logic signed [ACCW-1:0]               rnd_w [NF];
	logic signed [ftpd_pkg::TORQUE_W-1:0] tq_w  [NF];

	always_comb begin
		for (int i = 0; i < NF; i++) begin
			acc_w[i] = ACCW'(pa_s3[i]) - ACCW'(pr_s3[i])
				+ ACCW'(2 ** (ftpd_pkg::TQ_SHIFT - 1));
			rnd_w[i] = acc_w[i] >>> ftpd_pkg::TQ_SHIFT;
			if (rnd_w[i] > TQ_HI) begin
				tq_w[i] = ftpd_pkg::TORQUE_W'(TQ_HI);
			end else if (rnd_w[i] < TQ_LO) begin
				tq_w[i] = ftpd_pkg::TORQUE_W'(TQ_LO);
			end else begin
				tq_w[i] = ftpd_pkg::TORQUE_W'(rnd_w[i]);
			end
		end
	end

	logic signed [ftpd_pkg::TORQUE_W-1:0] tq_s4 [NF];

	always_ff @(posedge clk) begin
		if (v_s3 && en4) begin
			for (int i = 0; i < NF; i++) begin
				tq_s4[i] <= tq_w[i];
			end
		end
	end

	assign torque_front_right = tq_s4[ftpd_pkg::IX_FR];
	assign torque_front_left  = tq_s4[ftpd_pkg::IX_FL];
	assign torque_rear_right  = tq_s4[ftpd_pkg::IX_RR];
	assign torque_rear_left   = tq_s4[ftpd_pkg::IX_RL];

	// once primed, the servo stays primed until reset
	assert property (@(posedge clk) disable iff (!arst_n) primed_q |=> primed_q)
		else $error("primed flag dropped");

	// no beat can sit past the target stage before the servo is primed
	assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> (!v_s2 && !v_s3 && !v_s4))
		else $error("beat past target stage while unprimed");

	// a taking receiver never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// an accepted beat lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted beat lost at stage 1");

endmodule
